/* rtl/core/rmst_pkg.sv */
// ----------------------------------------------------------------------------
// rmst_pkg
// Shared types and constants for the range-minimum segment tree core.
// ----------------------------------------------------------------------------
`default_nettype none

package rmst_pkg;

	localparam int VALUE_W = 32;
	localparam int POS_W   = 10;
	localparam int RANGE_W = 11;

	typedef logic signed [VALUE_W-1:0] value_t;

	// identity of the minimum, the largest signed value
	localparam value_t IDENTITY = value_t'(32'h7FFF_FFFF);

	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_QUERY  = 1'b1;

	function automatic value_t smaller(input value_t a, input value_t b);
		smaller = (a < b) ? a : b;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/range_min_segment_tree_core.sv */
// ----------------------------------------------------------------------------
// range_min_segment_tree_core
// Segment tree of signed minimums over LEAVES leaves, held in one node
// memory and walked by a small sequencer around a shared compare unit.
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload
//  -------   ------------------   ----------------------------------------------
//  command   start / busy         command, position, new_value,
//                                 range_low, range_high
//  result    done (one cycle)     minimum
//
//  reset: the node memory is cleared to the identity, one node a cycle, all
//    2*LEAVES nodes after arst_n rises; busy is high throughout
//  update: the leaf is written in the transfer cycle, then the S_UPD walk
//    writes one parent node per level on the single node memory port
//  query: busy states S_QA and S_QB at each tree level, one memory read each
//    side; an empty range reports the cycle after transfer
//  done is high for exactly one cycle and cannot be stalled
//
`default_nettype none

module range_min_segment_tree_core #(
	parameter int LEAVES = 1024
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        start,
	output logic                       busy,
	input  wire                        command,
	input  wire  [rmst_pkg::POS_W-1:0]   position,
	input  wire signed [rmst_pkg::VALUE_W-1:0] new_value,
	input  wire  [rmst_pkg::RANGE_W-1:0] range_low,
	input  wire  [rmst_pkg::RANGE_W-1:0] range_high,
	output logic                       done,
	output rmst_pkg::value_t           minimum
);
	import rmst_pkg::*;

	localparam int LW    = $clog2(LEAVES);
	localparam int NW    = LW + 1;
	localparam int RW    = LW + 2;
	localparam int DEPTH = 2 * LEAVES;
	localparam logic [31:0] LEAVES_W = 32'(LEAVES);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CLR  = 3'd1;
	localparam logic [2:0] S_UPD  = 3'd2;
	localparam logic [2:0] S_QA   = 3'd3;
	localparam logic [2:0] S_QB   = 3'd4;

	value_t mem [DEPTH];
	value_t rdata_q;

	logic [2:0]    state_q;
	logic [NW-1:0] clr_q;
	logic [NW-1:0] k_q;
	logic [RW-1:0] l_q;
	logic [RW-1:0] r_q;
	value_t        cur_q;
	value_t        best_q;
	logic          pend_q;

	logic          acc;
	logic          pos_ok;
	logic [31:0]   lo32;
	logic [31:0]   hi32;
	logic          empty;
	logic [NW-1:0] leaf;
	logic [NW-1:0] parent;
	value_t        cmp_a;
	value_t        cmp_min;
	value_t        upd_min;
	value_t        best_fold;
	logic          we;
	logic [NW-1:0] waddr;
	value_t        wdata;
	logic [NW-1:0] raddr;

	assign busy   = (state_q != S_IDLE);
	assign acc    = start && !busy;
	assign pos_ok = (32'(position) < LEAVES_W);
	assign lo32   = 32'(range_low);
	assign hi32   = (32'(range_high) > LEAVES_W) ? LEAVES_W : 32'(range_high);
	assign empty  = (lo32 >= hi32);
	assign leaf   = NW'(LEAVES_W + 32'(position));
	assign parent = k_q >> 1;
	// one compare unit, shared by the update walk and the query walk
	assign cmp_a     = (state_q == S_UPD) ? cur_q : best_q;
	assign cmp_min   = smaller(cmp_a, rdata_q);
	assign upd_min   = cmp_min;
	// fold in the node read in the previous cycle
	assign best_fold = pend_q ? cmp_min : best_q;

	always_comb begin
		we    = 1'b0;
		waddr = leaf;
		wdata = new_value;
		raddr = leaf ^ NW'(1);
		case (state_q)
			S_IDLE: begin
				we = acc && (command == CMD_UPDATE) && pos_ok;
			end
			S_CLR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = IDENTITY;
			end
			S_UPD: begin
				we    = 1'b1;
				waddr = parent;
				wdata = upd_min;
				raddr = parent ^ NW'(1);
			end
			S_QA: begin
				raddr = NW'(l_q);
			end
			S_QB: begin
				raddr = NW'(r_q - RW'(1));
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// node memory, one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			k_q     <= '0;
			l_q     <= '0;
			r_q     <= '0;
			cur_q   <= IDENTITY;
			best_q  <= IDENTITY;
			minimum <= IDENTITY;
			pend_q  <= 1'b0;
			done    <= 1'b0;
		end else begin
			done   <= 1'b0;
			pend_q <= 1'b0;
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + NW'(1);
					if (clr_q == NW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (acc && (command == CMD_UPDATE) && pos_ok) begin
						k_q     <= leaf;
						cur_q   <= new_value;
						state_q <= S_UPD;
					end else if (acc && (command == CMD_QUERY)) begin
						if (empty) begin
							minimum <= IDENTITY;
							done    <= 1'b1;
						end else begin
							l_q     <= RW'(lo32 + LEAVES_W);
							r_q     <= RW'(hi32 + LEAVES_W);
							best_q  <= IDENTITY;
							state_q <= S_QA;
						end
					end
				end
				S_UPD: begin
					cur_q <= upd_min;
					k_q   <= parent;
					if (parent == NW'(1)) begin
						state_q <= S_IDLE;
					end
				end
				S_QA: begin
					best_q <= best_fold;
					if (l_q < r_q) begin
						if (l_q[0]) begin
							pend_q <= 1'b1;
							l_q    <= l_q + RW'(1);
						end
						state_q <= S_QB;
					end else begin
						minimum <= best_fold;
						done    <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_QB: begin
					best_q  <= best_fold;
					pend_q  <= r_q[0];
					l_q     <= l_q >> 1;
					// odd r: (r-1)>>1 equals r>>1
					r_q     <= r_q >> 1;
					state_q <= S_QA;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == S_QA)
			|| ($past(acc) && ($past(command) == CMD_QUERY)))
		else $error("result strobe without a finishing query");

	a_pend_src: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (($past(state_q) == S_QA) || ($past(state_q) == S_QB)))
		else $error("pending read outside a query walk");

	a_upd_node: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD) |-> (k_q > NW'(1)))
		else $error("update walk past the root");

	a_query_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_QA) || (state_q == S_QB)) |-> (l_q <= r_q))
		else $error("query bounds crossed");

	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD) |=> !done)
		else $error("update produced a result");

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for range_min_segment_tree_core: drives leaf updates
// and range queries over the start/busy port and compares every minimum
// against a software segment tree kept in a small scoreboard class.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import rmst_pkg::*;

	localparam int          LEAVES         = 1024;
	localparam int          CLK_PERIOD     = 20;
	localparam int          RESET_CYCLES   = 6;
	localparam int          MAX_GAP        = 18;
	localparam int          RANDOM_ITEMS   = 1280;
	localparam int          TAIL_CYCLES    = 64;
	localparam int unsigned WATCHDOG_LIMIT = 10000;

	typedef logic [POS_W-1:0]   pos_t;
	typedef logic [RANGE_W-1:0] range_t;

	class range_min_scoreboard;
		value_t      node_min [2*LEAVES];
		value_t      awaited_minimums [$];
		int unsigned errors;

		function new();
			foreach (node_min[i])
				node_min[i] = IDENTITY;
			errors = 0;
		endfunction

		function value_t range_minimum(int unsigned lo, int unsigned hi);
			value_t      best;
			int unsigned l;
			int unsigned r;
			best = IDENTITY;
			if (hi > LEAVES)
				hi = LEAVES;
			if (lo >= hi)
				return best;
			l = lo + LEAVES;
			r = hi + LEAVES;
			while (l < r) begin
				if (l & 1) begin
					if (node_min[l] < best)
						best = node_min[l];
					l++;
				end
				if (r & 1) begin
					r--;
					if (node_min[r] < best)
						best = node_min[r];
				end
				l = l >> 1;
				r = r >> 1;
			end
			return best;
		endfunction

		// called for every accepted transfer on the command side
		function void note_command(logic cmd, pos_t pos, value_t val, range_t lo, range_t hi);
			int unsigned k;
			if (cmd == CMD_UPDATE) begin
				k = pos + LEAVES;
				node_min[k] = val;
				while (k > 1) begin
					k = k >> 1;
					node_min[k] = (node_min[2*k] < node_min[2*k+1]) ?
						node_min[2*k] : node_min[2*k+1];
				end
			end else begin
				awaited_minimums.insert(awaited_minimums.size(), range_minimum(lo, hi));
			end
		endfunction

		function void check_minimum(value_t got);
			value_t want;
			if (awaited_minimums.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %0d", $time, got);
				errors++;
			end else begin
				want = awaited_minimums.pop_front();
				if (got !== want) begin
					$display("%0t: minimum mismatch, expected %0d, actual %0d",
						$time, want, got);
					errors++;
				end
			end
		endfunction

		function int pending();
			return awaited_minimums.size();
		endfunction
	endclass

	logic   clk        = 1'b0;
	logic   arst_n     = 1'b0;
	logic   start      = 1'b0;
	logic   command    = CMD_UPDATE;
	pos_t   position   = '0;
	value_t new_value  = '0;
	range_t range_low  = '0;
	range_t range_high = '0;
	logic   busy;
	logic   done;
	value_t minimum;

	range_min_scoreboard sb = new();
	bit                  burst = 1'b0;
	int unsigned         quiet_cycles = 0;

	range_min_segment_tree_core #(
		.LEAVES(LEAVES)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.command   (command),
		.position  (position),
		.new_value (new_value),
		.range_low (range_low),
		.range_high(range_high),
		.done      (done),
		.minimum   (minimum)
	);

	always #(CLK_PERIOD/2) clk = ~clk;

	// transfers are noted before results are checked, so a result in the
	// same cycle as its own command would still find its expectation
	always @(posedge clk) begin
		if (arst_n && start === 1'b1 && busy === 1'b0) begin
			sb.note_command(command, position, new_value, range_low, range_high);
			quiet_cycles <= 0;
		end else if (arst_n && done === 1'b1) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (arst_n && done === 1'b1)
			sb.check_minimum(minimum);
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired", $time);
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic value_t random_value();
		case ($urandom_range(0, 7))
			0:       return value_t'(32'h8000_0000);
			1:       return IDENTITY;
			2:       return value_t'(int'($urandom_range(0, 8)) - 4);
			3, 4:    return value_t'(int'($urandom_range(0, 2000)) - 1000);
			default: return value_t'($urandom);
		endcase
	endfunction

	task automatic send_command(input logic cmd, input pos_t pos, input value_t val,
			input range_t lo, input range_t hi);
		int unsigned gap;
		gap = burst ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start      <= 1'b1;
		command    <= cmd;
		position   <= pos;
		new_value  <= val;
		range_low  <= lo;
		range_high <= hi;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
	endtask

	// unused fields carry random junk
	task automatic do_update(input pos_t pos, input value_t val);
		send_command(CMD_UPDATE, pos, val, range_t'($urandom), range_t'($urandom));
	endtask

	task automatic do_query(input range_t lo, input range_t hi);
		send_command(CMD_QUERY, pos_t'($urandom), value_t'($urandom), lo, hi);
	endtask

	initial begin
		int unsigned n;
		int unsigned a;
		int unsigned hot_base;
		range_t      lo;
		range_t      hi;
		pos_t        pos;

		hot_base = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// directed part: empty tree, extreme leaves, empty and clamped ranges
		do_query(11'd0, 11'd1024);
		do_update(10'd0, value_t'(32'h8000_0000));
		do_update(10'd1023, IDENTITY);
		do_update(10'd512, value_t'(0));
		do_update(10'd1, value_t'(-1));
		do_update(10'h3FF, value_t'(32'h7FFF_FFFE));
		do_query(11'd0, 11'd1024);
		do_query(11'd1, 11'd1024);
		do_query(11'd2, 11'd1023);
		do_query(11'd1023, 11'd1024);
		do_query(11'd0, 11'd1);
		do_query(11'd512, 11'd513);
		do_query(11'd5, 11'd5);
		do_query(11'd700, 11'd3);
		do_query(11'd1000, 11'd2047);
		do_query(11'd2, 11'd1025);
		do_query(11'd1024, 11'd1024);
		do_query(11'd1024, 11'd2047);
		do_query(11'd2047, 11'd2047);
		do_query(11'd1500, 11'd2000);
		do_query(11'd0, 11'd0);
		do_update(10'd0, IDENTITY);
		do_query(11'd0, 11'd2);
		do_query(11'd0, 11'd2047);

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 64 == 0)
				burst = ($urandom_range(0, 3) == 0);
			if (n % 128 == 0)
				hot_base = $urandom_range(0, LEAVES - 32);
			if (n == RANDOM_ITEMS / 2) begin
				// hold off until every query so far has reported
				start <= 1'b0;
				while (sb.pending() != 0)
					@(posedge clk);
				repeat (TAIL_CYCLES) @(posedge clk);
			end
			if ($urandom_range(0, 99) < 45) begin
				if ($urandom_range(0, 1) == 0)
					pos = pos_t'($urandom);
				else
					pos = pos_t'(hot_base + $urandom_range(0, 31));
				do_update(pos, random_value());
			end else begin
				case ($urandom_range(0, 9))
					0: begin
						lo = range_t'($urandom);
						hi = range_t'($urandom);
					end
					1: begin
						lo = range_t'($urandom_range(0, LEAVES));
						hi = lo;
					end
					2: begin
						lo = range_t'($urandom_range(0, LEAVES - 1));
						hi = range_t'($urandom_range(LEAVES + 1, 2047));
					end
					3, 4, 5: begin
						a  = $urandom_range(0, LEAVES - 1);
						lo = range_t'(a);
						a  = a + $urandom_range(1, 16);
						hi = range_t'((a > LEAVES) ? LEAVES : a);
					end
					6, 7: begin
						a  = $urandom_range(0, LEAVES - 1);
						lo = range_t'(a);
						hi = range_t'($urandom_range(a + 1, LEAVES));
					end
					8: begin
						lo = range_t'(hot_base + $urandom_range(0, 15));
						hi = range_t'(hot_base + $urandom_range(16, 32));
					end
					default: begin
						lo = range_t'($urandom_range(0, 1) ? 0 : $urandom_range(0, LEAVES - 1));
						hi = range_t'(LEAVES);
					end
				endcase
				do_query(lo, hi);
			end
		end

		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
